>>> hdl/rpb_pkg.sv
// rpb_pkg: shared types, constants and helper functions of the rgb565 pixel blender
// no dependencies; imported by every module of the block

package rpb_pkg;

  // source pixel formats
  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGBX8888 = 3'd1,
    FMT_BGRA8888 = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_RGB565   = 3'd4
  } src_fmt_e;

  // blend modes (code 3 behaves as premultiplied)
  typedef enum logic [1:0] {
    BLEND_NONE     = 2'd0,
    BLEND_PREMULT  = 2'd1,
    BLEND_COVERAGE = 2'd2
  } blend_mode_e;

  // register map
  localparam int unsigned CfgAddrWidth  = 3;
  localparam logic        RegPlaneAlpha = 1'b0;
  localparam logic [7:0]  PlaneAlphaRst = 8'hff;
  localparam logic [7:0]  AlphaOpaque   = 8'hff;
  localparam logic [15:0] RoundBias     = 16'd127;

  // (p + 127) / 255 for p up to 255*255, by reciprocal correction
  function automatic logic [7:0] div255_rnd(input logic [15:0] p);
    logic [16:0] t;
    logic [16:0] q;
    t = {1'b0, p} + {1'b0, RoundBias};
    q = t + {9'd0, t[15:8]} + 17'd1;
    return q[15:8];
  endfunction

  // pack 8-bit channels into rgb565
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // first stage contents: decoded source and alpha product
  typedef struct packed {
    logic        valid;
    logic        fmt_ok;
    logic        is565;
    logic        coverage;
    logic [7:0]  pa;
    logic [15:0] prod;
    logic [15:0] word;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] dst;
  } rpb_s1_t;

  // alpha stage to mix stage
  typedef struct packed {
    logic        valid;
    logic        wr_en;
    logic        opaque;
    logic [15:0] direct;
    logic [7:0]  cf;
    logic [7:0]  inv;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] dst;
  } rpb_s2_t;

  // products of the mix stage
  typedef struct packed {
    logic        valid;
    logic        wr_en;
    logic        opaque;
    logic [15:0] direct;
    logic [15:0] dst;
    logic [15:0] sr;
    logic [15:0] sg;
    logic [15:0] sb;
    logic [15:0] dr;
    logic [15:0] dg;
    logic [15:0] db;
  } rpb_s3_t;

endpackage

>>> hdl/rgb565_alpha_pixel_blender_top.sv
// channel   | signals                                           | transfer when
// ----------+---------------------------------------------------+----------------------
// pixel in  | start, src_format_i, blend_mode_i, src_byte0..3_i, | start high, busy low
//           | dst_pixel_i                                       |
// result    | done_o, out_pixel_o, write_enable_o               | done_o high, 1 cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata      | psel, penable, pwrite
//
// one pixel enters every cycle; busy is never raised
// each result passes four registered stages after its transfer: decode and alpha product, alpha
// division, six channel multiplies, then divide, saturating add and repack
// reset clears the valid bits of all four stages and loads plane alpha 255
// the receiver cannot stall, so the pipeline never holds
// depends on rpb_pkg, rpb_cfg, rpb_alpha, rpb_mix

module rgb565_alpha_pixel_blender_top
  import rpb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              src_format_i,
  input  logic [1:0]              blend_mode_i,
  input  logic [7:0]              src_byte0_i,
  input  logic [7:0]              src_byte1_i,
  input  logic [7:0]              src_byte2_i,
  input  logic [7:0]              src_byte3_i,
  input  logic [15:0]             dst_pixel_i,
  output logic                    done_o,
  output logic [15:0]             out_pixel_o,
  output logic                    write_enable_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [7:0] layer_alpha;
  logic       in_xfer;
  rpb_s2_t    s2;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // configuration register
  rpb_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .layer_alpha_o (layer_alpha)
  );

  // alpha stages
  rpb_alpha u_alpha (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_xfer),
    .layer_alpha_i (layer_alpha),
    .src_format_i  (src_format_i),
    .blend_mode_i  (blend_mode_i),
    .src_byte0_i   (src_byte0_i),
    .src_byte1_i   (src_byte1_i),
    .src_byte2_i   (src_byte2_i),
    .src_byte3_i   (src_byte3_i),
    .dst_pixel_i   (dst_pixel_i),
    .s2_o          (s2)
  );

  // mix stages
  rpb_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s2_i           (s2),
    .done_o         (done_o),
    .out_pixel_o    (out_pixel_o),
    .write_enable_o (write_enable_o)
  );

`ifndef SYNTHESIS
  // every transfer gives a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##4 done_o)
    else $error("result missing four cycles after transfer");

  // a result only follows a transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_xfer, 4))
    else $error("result without a transfer");

  // an unknown format never writes
  a_bad_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(src_format_i, 4) > FMT_RGB565)) |-> !write_enable_o)
    else $error("write for unknown format");

  // an unwritten pixel keeps the destination
  a_keep_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !write_enable_o) |-> (out_pixel_o == $past(dst_pixel_i, 4)))
    else $error("destination altered without write");
`endif

endmodule

>>> hdl/rpb_cfg.sv
// rpb_cfg: apb-style register port holding the plane alpha
// depends on rpb_pkg

module rpb_cfg
  import rpb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [7:0]              layer_alpha_o
);

  logic [7:0] layer_alpha_q, layer_alpha_d;
  logic       wr_sel;

  assign pready = 1'b1;

  // register write on the access phase
  assign wr_sel = psel && penable && pwrite && (paddr[CfgAddrWidth-1] == RegPlaneAlpha);

  always_comb begin
    layer_alpha_d = layer_alpha_q;
    if (wr_sel) begin
      layer_alpha_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_alpha_q <= PlaneAlphaRst;
    end else begin
      layer_alpha_q <= layer_alpha_d;
    end
  end

  // read back
  assign prdata = (paddr[CfgAddrWidth-1] == RegPlaneAlpha) ? {24'd0, layer_alpha_q} : 32'd0;
  assign layer_alpha_o = layer_alpha_q;

endmodule

>>> hdl/rpb_alpha.sv
// rpb_alpha: source decode, effective alpha product and alpha division (stages 1 and 2)
// depends on rpb_pkg

module rpb_alpha
  import rpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  layer_alpha_i,
  input  logic [2:0]  src_format_i,
  input  logic [1:0]  blend_mode_i,
  input  logic [7:0]  src_byte0_i,
  input  logic [7:0]  src_byte1_i,
  input  logic [7:0]  src_byte2_i,
  input  logic [7:0]  src_byte3_i,
  input  logic [15:0] dst_pixel_i,
  output rpb_s2_t     s2_o
);

  rpb_s1_t    s1_d, s1_q;
  rpb_s2_t    s2_d, s2_q;
  logic       has_alpha;
  logic [7:0] a_raw;
  logic [15:0] word;
  logic [7:0] a_eff;

  // stage 1: decode format and form alpha times plane alpha
  always_comb begin
    word      = {src_byte1_i, src_byte0_i};
    has_alpha = (src_format_i == FMT_RGBA8888) || (src_format_i == FMT_BGRA8888);
    a_raw     = ((blend_mode_i == BLEND_NONE) || !has_alpha) ? AlphaOpaque : src_byte3_i;
    s1_d.valid    = in_valid_i;
    s1_d.fmt_ok   = (src_format_i <= FMT_RGB565);
    s1_d.is565    = (src_format_i == FMT_RGB565);
    s1_d.coverage = (blend_mode_i == BLEND_COVERAGE);
    s1_d.pa       = layer_alpha_i;
    s1_d.prod     = 16'(a_raw * layer_alpha_i);
    s1_d.word     = word;
    s1_d.dst      = dst_pixel_i;
    case (src_format_i)
      FMT_RGB565: begin
        s1_d.r = {word[15:11], 3'd0};
        s1_d.g = {word[10:5], 2'd0};
        s1_d.b = {word[4:0], 3'd0};
      end
      FMT_BGRA8888: begin
        s1_d.r = src_byte2_i;
        s1_d.g = src_byte1_i;
        s1_d.b = src_byte0_i;
      end
      default: begin
        s1_d.r = src_byte0_i;
        s1_d.g = src_byte1_i;
        s1_d.b = src_byte2_i;
      end
    endcase
  end

  // stage 2: effective alpha, write decision and colour factor
  // an opaque plane divides a*255 back to a exactly
  always_comb begin
    a_eff        = div255_rnd(s1_q.prod);
    s2_d.valid   = s1_q.valid;
    s2_d.wr_en   = s1_q.fmt_ok && (a_eff != 8'd0);
    s2_d.opaque  = (a_eff == AlphaOpaque) && (s1_q.pa == AlphaOpaque);
    s2_d.direct  = s1_q.is565 ? s1_q.word : pack565(s1_q.r, s1_q.g, s1_q.b);
    s2_d.cf      = s1_q.coverage ? a_eff : s1_q.pa;
    s2_d.inv     = AlphaOpaque - a_eff;
    s2_d.r       = s1_q.r;
    s2_d.g       = s1_q.g;
    s2_d.b       = s1_q.b;
    s2_d.dst     = s1_q.dst;
  end

  // stage registers, cleared on reset so no valid bit survives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

>>> hdl/rpb_mix.sv
// rpb_mix: colour and destination scaling, saturating sum and repack (stages 3 and 4)
// depends on rpb_pkg

module rpb_mix
  import rpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rpb_s2_t     s2_i,
  output logic        done_o,
  output logic [15:0] out_pixel_o,
  output logic        write_enable_o
);

  rpb_s3_t     s3_d, s3_q;
  logic [7:0]  dr8, dg8, db8;
  logic [8:0]  sum_r, sum_g, sum_b;
  logic [7:0]  sat_r, sat_g, sat_b;
  logic        done_q, done_d;
  logic [15:0] pix_q, pix_d;
  logic        we_q, we_d;

  // stage 3: six 8x8 products
  always_comb begin
    dr8 = {s2_i.dst[15:11], 3'd0};
    dg8 = {s2_i.dst[10:5], 2'd0};
    db8 = {s2_i.dst[4:0], 3'd0};
    s3_d.valid  = s2_i.valid;
    s3_d.wr_en  = s2_i.wr_en;
    s3_d.opaque = s2_i.opaque;
    s3_d.direct = s2_i.direct;
    s3_d.dst    = s2_i.dst;
    s3_d.sr     = 16'(s2_i.r * s2_i.cf);
    s3_d.sg     = 16'(s2_i.g * s2_i.cf);
    s3_d.sb     = 16'(s2_i.b * s2_i.cf);
    s3_d.dr     = 16'(dr8 * s2_i.inv);
    s3_d.dg     = 16'(dg8 * s2_i.inv);
    s3_d.db     = 16'(db8 * s2_i.inv);
  end

  // stage 4: divide, add with saturation, select result
  always_comb begin
    sum_r = {1'b0, div255_rnd(s3_q.sr)} + {1'b0, div255_rnd(s3_q.dr)};
    sum_g = {1'b0, div255_rnd(s3_q.sg)} + {1'b0, div255_rnd(s3_q.dg)};
    sum_b = {1'b0, div255_rnd(s3_q.sb)} + {1'b0, div255_rnd(s3_q.db)};
    sat_r = sum_r[8] ? 8'hff : sum_r[7:0];
    sat_g = sum_g[8] ? 8'hff : sum_g[7:0];
    sat_b = sum_b[8] ? 8'hff : sum_b[7:0];
    done_d = s3_q.valid;
    we_d   = s3_q.wr_en;
    if (!s3_q.wr_en) begin
      pix_d = s3_q.dst;
    end else if (s3_q.opaque) begin
      pix_d = s3_q.direct;
    end else begin
      pix_d = pack565(sat_r, sat_g, sat_b);
    end
  end

  // stage registers, cleared on reset so no valid bit survives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q   <= '0;
      done_q <= 1'b0;
      pix_q  <= 16'd0;
      we_q   <= 1'b0;
    end else begin
      s3_q   <= s3_d;
      done_q <= done_d;
      pix_q  <= pix_d;
      we_q   <= we_d;
    end
  end

  assign done_o         = done_q;
  assign out_pixel_o    = pix_q;
  assign write_enable_o = we_q;

endmodule
